[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// Needs a clock and an active-low reset name passed in at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MLT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define MLT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen");
`else
`define MLT_ASSERT(lbl, clk, rst_n, prop)
`define MLT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

[hw/rtl/mlt_pkg.sv]
// Types and constants for the MAC learning table.
// No dependencies.
`timescale 1ns / 1ps
package mlt_pkg;
	localparam int TABLE_ENTRIES = 64;
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	localparam logic [1:0] ACT_IGNORE  = 2'd0;
	localparam logic [1:0] ACT_FLOOD   = 2'd1;
	localparam logic [1:0] ACT_FORWARD = 2'd2;

	localparam logic       REQ_PACKET = 1'b0;
	localparam logic       REQ_TICK   = 1'b1;

	localparam logic       CFG_MAX_AGE  = 1'b0;
	localparam logic       CFG_AGING_IV = 1'b1;

	localparam logic [15:0] MAX_AGE_RST  = 16'd300;
	localparam logic [7:0]  AGING_IV_RST = 8'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_SWEEP
	} state_t;

	typedef struct packed {
		logic [47:0] mac;
		logic [63:0] sw;
		logic [31:0] port;
		logic [31:0] stamp;
	} entry_t;
endpackage

[hw/rtl/mac_learning_table_with_aging.sv]
// MAC learning table with aging: top level, single module.
// Depends on mlt_pkg and assert_macros.svh.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------------
//  in      | in_valid  | in_stall  | req_type switch_id src_mac dst_mac ingress_port
//  out     | out_valid | out_stall | action egress_port switch_id_out learn_dropped
//  cfg     | cfg_we    | (none)    | cfg_index cfg_data
//
// A packet request scans the entry memory one entry per cycle through its single
// read port, then learns the source in ST_WRITE and registers the result.
// A port-zero packet answers in the cycle after its accept, with no scan; a tick
// gives no result and may trigger an aging sweep over the same read port.
// Reset clears the valid flags at once; the entry memory needs no clearing.
// One request at a time: in_stall is high while busy or while a result waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mac_learning_table_with_aging (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [63:0] switch_id,
	input  logic [47:0] src_mac,
	input  logic [47:0] dst_mac,
	input  logic [31:0] ingress_port,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic [31:0] egress_port,
	output logic [63:0] switch_id_out,
	output logic        learn_dropped,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import mlt_pkg::*;

	// entry storage: valid flags in flops, everything else in a sync RAM
	entry_t                   mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	state_t       st_q, st_d;
	logic [15:0]  max_age_q;
	logic [7:0]   aging_iv_q;
	logic [31:0]  secs_q;
	logic [7:0]   sweep_cnt_q;
	logic [7:0]   cnt_inc;

	// latched request
	logic [63:0]  sw_q;
	logic [47:0]  src_q, dst_q;
	logic [31:0]  port_q;

	// scan pipeline
	logic [CW-1:0] addr_q;
	logic          rd_en;
	logic          scan_done;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	entry_t        rd_s1;
	logic          ent_live;

	// scan results
	logic          src_hit_q, dst_hit_q, free_q;
	logic [AW-1:0] src_idx_q, free_idx_q;
	logic [31:0]   dst_port_q;

	logic          out_valid_q;
	logic [1:0]    act_q;
	logic [31:0]   egr_q;
	logic [63:0]   swo_q;
	logic          drop_q;

	logic          acc;
	logic          learn_ok;
	logic [AW-1:0] wr_idx;
	logic [31:0]   elapsed;

	assign acc       = in_valid && !in_stall;
	assign cnt_inc   = sweep_cnt_q + 8'd1;
	assign scan_done = (addr_q == CW'(TABLE_ENTRIES)) && !vld_s1;
	assign ent_live  = valid_q[idx_s1];
	assign learn_ok  = src_hit_q || free_q;
	assign wr_idx    = src_hit_q ? src_idx_q : free_idx_q;
	assign elapsed   = secs_q - rd_s1.stamp;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (acc) begin
					if (req_type == REQ_TICK) begin
						if (cnt_inc >= aging_iv_q) st_d = ST_SWEEP;
					end else if (ingress_port != 32'd0) begin
						st_d = ST_SCAN;
					end
				end
			end
			ST_SCAN:  if (scan_done) st_d = ST_WRITE;
			ST_WRITE: st_d = ST_IDLE;
			ST_SWEEP: if (scan_done) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		case (st_q)
			ST_IDLE:  in_stall = out_valid_q;
			ST_SCAN,
			ST_SWEEP: rd_en = (addr_q != CW'(TABLE_ENTRIES));
			ST_WRITE: in_stall = 1'b1;
			default:  in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			max_age_q   <= MAX_AGE_RST;
			aging_iv_q  <= AGING_IV_RST;
			secs_q      <= '0;
			sweep_cnt_q <= '0;
			valid_q     <= '0;
			addr_q      <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				if (cfg_index == CFG_MAX_AGE) max_age_q <= cfg_data;
				else aging_iv_q <= cfg_data[7:0];
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			vld_s1 <= rd_en;
			if (rd_en) addr_q <= addr_q + CW'(1);
			if (st_q == ST_IDLE) addr_q <= '0;

			if (st_q == ST_IDLE && acc) begin
				if (req_type == REQ_TICK) begin
					secs_q      <= secs_q + 32'd1;
					sweep_cnt_q <= (cnt_inc >= aging_iv_q) ? 8'd0 : cnt_inc;
				end else if (ingress_port == 32'd0) begin
					out_valid_q <= 1'b1;
				end
			end

			// aging: drop entries idle longer than max_age
			if (st_q == ST_SWEEP && vld_s1 && ent_live &&
			    elapsed > {16'd0, max_age_q})
				valid_q[idx_s1] <= 1'b0;

			if (st_q == ST_WRITE) begin
				if (learn_ok) valid_q[wr_idx] <= 1'b1;
				out_valid_q <= 1'b1;
			end
		end
	end

	// memory: one read, one write port
	always_ff @(posedge clk) begin
		if (rd_en) rd_s1 <= mem[addr_q[AW-1:0]];
		idx_s1 <= addr_q[AW-1:0];
		if (st_q == ST_WRITE && learn_ok)
			mem[wr_idx] <= '{mac: src_q, sw: sw_q, port: port_q, stamp: secs_q};
	end

	// request latch, scan bookkeeping, result payload
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && acc) begin
			sw_q      <= switch_id;
			src_q     <= src_mac;
			dst_q     <= dst_mac;
			port_q    <= ingress_port;
			src_hit_q <= 1'b0;
			dst_hit_q <= 1'b0;
			free_q    <= 1'b0;
			act_q     <= ACT_IGNORE;
			egr_q     <= '0;
			swo_q     <= switch_id;
			drop_q    <= 1'b0;
		end
		if (st_q == ST_SCAN && vld_s1) begin
			if (!ent_live) begin
				if (!free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end else if (rd_s1.sw == sw_q) begin
				if (rd_s1.mac == src_q) begin
					src_hit_q <= 1'b1;
					src_idx_q <= idx_s1;
				end
				if (rd_s1.mac == dst_q) begin
					dst_hit_q  <= 1'b1;
					dst_port_q <= rd_s1.port;
				end
			end
		end
		if (st_q == ST_WRITE) begin
			swo_q  <= sw_q;
			drop_q <= !learn_ok;
			// lookup follows the learn: same address sees the new port
			if (learn_ok && dst_q == src_q) begin
				act_q <= ACT_FORWARD;
				egr_q <= port_q;
			end else if (dst_hit_q) begin
				act_q <= ACT_FORWARD;
				egr_q <= dst_port_q;
			end else begin
				act_q <= ACT_FLOOD;
				egr_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = act_q;
	assign egress_port   = egr_q;
	assign switch_id_out = swo_q;
	assign learn_dropped = drop_q;

	`MLT_ASSERT(a_busy_when_result, clk, arst_n, out_valid_q |-> in_stall)
	`MLT_NEVER(a_no_result_in_sweep, clk, arst_n, (st_q == ST_SWEEP) && out_valid_q)
	`MLT_ASSERT(a_write_gives_result, clk, arst_n, (st_q == ST_WRITE) |=> out_valid_q)
	`MLT_ASSERT(a_read_only_scanning, clk, arst_n,
		rd_en |-> (st_q == ST_SCAN || st_q == ST_SWEEP))
endmodule

[verif/tb_mac_learning_table_with_aging.sv]
// Testbench for the MAC learning table with aging: scoreboard class, drivers, run sequence.
// Depends on mlt_pkg and on the mac_learning_table_with_aging RTL.
`timescale 1ns / 1ps
module tb_mac_learning_table_with_aging;
	import mlt_pkg::*;

	// One forwarding decision as it should appear on the output channel
	typedef struct packed {
		logic [1:0]  act;
		logic [31:0] egress;
		logic [63:0] sw;
		logic        dropped;
	} decision_t;

	// Shadow copy of the table, the clock and the aging registers.
	// Every accepted request updates it; packets push the decision they should produce.
	class mac_table_sb;
		bit          vld [TABLE_ENTRIES];
		logic [47:0] mac [TABLE_ENTRIES];
		logic [63:0] swid [TABLE_ENTRIES];
		logic [31:0] port [TABLE_ENTRIES];
		logic [31:0] stamp [TABLE_ENTRIES];
		logic [31:0] seconds;
		logic [7:0]  tick_cnt;
		logic [15:0] max_age;
		logic [7:0]  aging_iv;
		decision_t   pending_q[$];
		int errors, checked, n_fwd, n_flood, n_drop, n_sweep, n_ticks;

		function new();
			foreach (vld[i]) vld[i] = 0;
			seconds = 0;
			tick_cnt = 0;
			max_age = MAX_AGE_RST;
			aging_iv = AGING_IV_RST;
		endfunction

		function void set_cfg(logic [15:0] ma, logic [7:0] ai);
			max_age = ma;
			aging_iv = ai;
		endfunction

		function int lookup(logic [63:0] s, logic [47:0] m);
			for (int i = 0; i < TABLE_ENTRIES; i++)
				if (vld[i] && swid[i] == s && mac[i] == m) return i;
			return -1;
		endfunction

		function void note_request(logic rq, logic [63:0] s, logic [47:0] src,
				logic [47:0] dst, logic [31:0] p);
			decision_t d;
			int idx;
			logic [31:0] elapsed;
			if (rq == REQ_TICK) begin
				n_ticks++;
				seconds = seconds + 32'd1;
				tick_cnt = tick_cnt + 8'd1;
				if (tick_cnt >= aging_iv) begin
					n_sweep++;
					for (int i = 0; i < TABLE_ENTRIES; i++) begin
						elapsed = seconds - stamp[i];
						if (vld[i] && elapsed > {16'd0, max_age}) vld[i] = 0;
					end
					tick_cnt = 0;
				end
				return;
			end
			d = '{act: ACT_IGNORE, egress: 32'd0, sw: s, dropped: 1'b0};
			if (p != 32'd0) begin
				idx = lookup(s, src);
				if (idx < 0) begin
					for (int i = 0; i < TABLE_ENTRIES; i++)
						if (!vld[i]) begin
							idx = i;
							break;
						end
					if (idx >= 0) begin
						vld[idx] = 1;
						mac[idx] = src;
						swid[idx] = s;
					end else begin
						d.dropped = 1'b1;
						n_drop++;
					end
				end
				if (idx >= 0) begin
					port[idx] = p;
					stamp[idx] = seconds;
				end
				// lookup after the learn: same src and dst hits the fresh entry
				idx = lookup(s, dst);
				if (idx >= 0) begin
					d.act = ACT_FORWARD;
					d.egress = port[idx];
					n_fwd++;
				end else begin
					d.act = ACT_FLOOD;
					n_flood++;
				end
			end
			pending_q.push_back(d);
		endfunction

		function void check_result(logic [1:0] a, logic [31:0] e, logic [63:0] s, logic dr);
			decision_t d;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result action %0d egress %h switch %h dropped %0d",
					$time, a, e, s, dr);
				errors++;
				return;
			end
			d = pending_q.pop_front();
			checked++;
			if (a !== d.act) begin
				$display("%0t: action expected %0d actual %0d", $time, d.act, a);
				errors++;
			end
			if (e !== d.egress) begin
				$display("%0t: egress_port expected %h actual %h", $time, d.egress, e);
				errors++;
			end
			if (s !== d.sw) begin
				$display("%0t: switch_id_out expected %h actual %h", $time, d.sw, s);
				errors++;
			end
			if (dr !== d.dropped) begin
				$display("%0t: learn_dropped expected %0d actual %0d", $time, d.dropped, dr);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        req_type;
	logic [63:0] switch_id;
	logic [47:0] src_mac;
	logic [47:0] dst_mac;
	logic [31:0] ingress_port;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  action;
	logic [31:0] egress_port;
	logic [63:0] switch_id_out;
	logic        learn_dropped;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	mac_table_sb sb;

	// small pools so lookups hit and refreshes happen
	logic [63:0] sw_pool [4];
	logic [47:0] mac_pool [16];

	bit no_idle;     // phases with back-to-back traffic on both sides
	bit hold_req;    // asks the receiver for one long hold-off

	mac_learning_table_with_aging u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .switch_id(switch_id), .src_mac(src_mac),
		.dst_mac(dst_mac), .ingress_port(ingress_port),
		.out_valid(out_valid), .out_stall(out_stall),
		.action(action), .egress_port(egress_port),
		.switch_id_out(switch_id_out), .learn_dropped(learn_dropped),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Safety net: far beyond the slowest legal run of traffic plus receiver holds.
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

	// Output monitor: every accepted result goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(action, egress_port, switch_id_out, learn_dropped);
	end

	// Receiver: random hold-off before each result, optionally one very long one.
	// While held, the block keeps its result and the sender backs up behind in_stall.
	initial begin : receiver
		int g;
		@(posedge arst_n);
		forever begin
			g = no_idle ? 0 : $urandom_range(0, 18);
			if (hold_req) begin
				g = 300;
				hold_req = 0;
			end
			if (g > 0) begin
				@(negedge clk) out_stall <= 1'b1;
				repeat (g - 1) @(negedge clk);
			end
			@(negedge clk) out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Sender: offers one request after a random gap and waits for the accept.
	// Valid stays high across back-to-back requests (gap 0).
	task automatic send_req(logic rq, logic [63:0] s, logic [47:0] src,
			logic [47:0] dst, logic [31:0] p);
		int g;
		g = no_idle ? 0 : $urandom_range(0, 18);
		if (g > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		req_type <= rq;
		switch_id <= s;
		src_mac <= src;
		dst_mac <= dst;
		ingress_port <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_request(rq, s, src, dst, p);
	endtask

	// Pause until every decision is back, then let a possible sweep finish
	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (TABLE_ENTRIES + 20) @(posedge clk);
	endtask

	// Both aging registers, on consecutive cycles; only called while idle
	task automatic set_aging(logic [15:0] ma, logic [7:0] ai);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAX_AGE;
		cfg_data <= ma;
		@(negedge clk);
		cfg_index <= CFG_AGING_IV;
		cfg_data <= {8'd0, ai};
		@(negedge clk) cfg_we <= 1'b0;
		sb.set_cfg(ma, ai);
	endtask

	task automatic rand_req(int tick_pct);
		logic [63:0] s;
		logic [47:0] src, dst;
		logic [31:0] p;
		s = ($urandom_range(0, 9) != 0) ? sw_pool[$urandom_range(0, 3)]
			: {$urandom, $urandom};
		src = ($urandom_range(0, 4) != 0) ? mac_pool[$urandom_range(0, 15)]
			: 48'({$urandom, $urandom});
		dst = ($urandom_range(0, 4) != 0) ? mac_pool[$urandom_range(0, 15)]
			: 48'({$urandom, $urandom});
		case ($urandom_range(0, 9))
			0: p = 32'd0;
			1, 2: p = $urandom;
			default: p = $urandom_range(1, 8);
		endcase
		if ($urandom_range(0, 99) < tick_pct)
			send_req(REQ_TICK, s, src, dst, p);
		else
			send_req(REQ_PACKET, s, src, dst, p);
	endtask

	task automatic rand_phase(int n, int tick_pct);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
			rand_req(tick_pct);
		end
		no_idle = 0;
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		req_type = REQ_PACKET;
		switch_id = '0;
		src_mac = '0;
		dst_mac = '0;
		ingress_port = '0;
		out_stall = 0;
		cfg_we = 0;
		cfg_index = CFG_MAX_AGE;
		cfg_data = '0;
		no_idle = 0;
		hold_req = 0;
		sb = new();
		foreach (sw_pool[i]) sw_pool[i] = {$urandom, $urandom};
		foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: reset aging values, field extremes, port zero, hits, self-lookup
		send_req(REQ_PACKET, '1, '1, '0, 32'd0);             // port zero: ignored
		send_req(REQ_PACKET, '1, '1, '1, 32'hFFFF_FFFF);     // src == dst, hits itself
		send_req(REQ_PACKET, '0, '0, '1, 32'd1);             // miss on other switch
		send_req(REQ_PACKET, '0, '1, '0, 32'd7);             // hit entry learned above
		send_req(REQ_PACKET, '1, '0, '1, 32'd3);             // forward to all-ones port
		send_req(REQ_PACKET, '1, '1, '0, 32'd5);             // refresh moves port
		send_req(REQ_PACKET, '1, '0, '1, 32'd2);             // now forwards to 5
		send_req(REQ_PACKET, '1, '0, '1, 32'd0);             // ignored, no refresh
		send_req(REQ_TICK, '1, '1, '1, 32'hFFFF_FFFF);       // tick, fields ignored
		send_req(REQ_TICK, '0, '0, '0, 32'd0);
		for (int i = 0; i < 4; i++) send_req(REQ_TICK, '0, '0, '0, 32'd0); // reset interval sweep
		send_req(REQ_PACKET, '1, mac_pool[0], '1, 32'h8000_0000);
		send_req(REQ_PACKET, 64'h8000_0000_0000_0000, 48'h8000_0000_0000,
			48'h0000_0000_0001, 32'h0000_0001);
		drain();

		// Random traffic with reset-like aging
		set_aging(16'd300, 8'd5);
		rand_phase(90, 15);
		drain();

		// Largest aging values; fill the table past capacity on one switch
		set_aging(16'hFFFF, 8'hFF);
		for (int i = 0; i < TABLE_ENTRIES + 6; i++)
			send_req(REQ_PACKET, sw_pool[0], {16'hA5A5, 32'(i)},
				{16'hA5A5, 32'($urandom_range(0, TABLE_ENTRIES + 8))},
				$urandom_range(1, 16));
		drain();

		// Zero and minimum: every tick sweeps, anything not stamped this second goes
		set_aging(16'd0, 8'd1);
		rand_phase(70, 30);
		drain();

		// Interval zero with a long receiver hold-off early in the phase
		set_aging(16'd3, 8'd0);
		hold_req = 1;
		rand_phase(70, 30);
		drain();

		// Interval counting from a leftover value; moderate age
		set_aging(16'd20, 8'd2);
		rand_phase(80, 20);
		drain();

		$display("Covered %0d decisions: %0d forward, %0d flood, %0d learn drops",
			sb.checked, sb.n_fwd, sb.n_flood, sb.n_drop);
		$display("Ticks %0d, aging sweeps %0d, six aging settings", sb.n_ticks, sb.n_sweep);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
